### sv/sparse_column_entry_decoder_top_defines.svh
// Assertion macros for the sparse column entry decoder checker
`ifndef SPARSE_COLUMN_ENTRY_DECODER_TOP_DEFINES_SVH
`define SPARSE_COLUMN_ENTRY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SCEDEC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SCEDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/scedec_pkg.sv
// Types and constants shared by the sparse column entry decoder files
package scedec_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned ThreshW = 31;
	localparam int unsigned CfgIdxW = 2;

	// index formats
	typedef enum logic [1:0] {
		IDX_RAW     = 2'd0,
		IDX_DELTA16 = 2'd1,
		IDX_DELTA32 = 2'd2
	} index_fmt_t;

	// stored value widths
	typedef enum logic [1:0] {
		VW_8  = 2'd0,
		VW_16 = 2'd1,
		VW_32 = 2'd2
	} value_width_t;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_INDEX_FORMAT = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_VALUE_WIDTH  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_THRESHOLD    = 2'd2;

	// 16-bit delta escape code
	localparam logic [15:0] ESCAPE_CODE = 16'h7FFF;

	// 2^30 / 127 = 4 * (2^21 + 2^14 + 2^7 + 1) + 4/127
	localparam logic [23:0] RECIP_Q8 = 24'h810204;

	// dequantizer result
	typedef struct packed {
		logic signed [WordW-1:0] value_q2_30;
		logic                    value_is_na;
		logic                    is_neighbor;
	} value_res_t;

endpackage

### sv/scedec_if.sv
// Valid/ready channel interfaces for entries and decoded results
interface scedec_entry_if;
	import scedec_pkg::*;

	logic             valid;
	logic             ready;
	logic             first_of_column;
	logic [WordW-1:0] column_index;
	logic [WordW-1:0] index_code;
	logic [WordW-1:0] overflow_delta;
	logic [WordW-1:0] value_code;

	modport source (output valid, first_of_column, column_index, index_code,
		overflow_delta, value_code, input ready);
	modport sink (input valid, first_of_column, column_index, index_code,
		overflow_delta, value_code, output ready);
endinterface

interface scedec_result_if;
	import scedec_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [WordW-1:0]        row_index;
	logic signed [WordW-1:0] value_q2_30;
	logic                    value_is_na;
	logic                    is_neighbor;

	modport source (output valid, row_index, value_q2_30, value_is_na, is_neighbor,
		input ready);
	modport sink (input valid, row_index, value_q2_30, value_is_na, is_neighbor,
		output ready);
endinterface

### sv/sparse_column_entry_decoder_top.sv
// Sparse column entry decoder: row index delta decode and value dequantize
// An accepted entry passes through the input register and then the result register.
// Throughput: one entry per cycle while the result register is empty or being taken.
// The input register, if empty, takes a new entry while a finished result waits to be taken.
// Reset clears both stage valids, the previous row to zero and the configuration
// registers to index format 2, value width 16 bits and threshold zero.
module sparse_column_entry_decoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scedec_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [scedec_pkg::ThreshW-1:0] cfg_data,
	scedec_entry_if.sink                   entry,
	scedec_result_if.source                result
);
	import scedec_pkg::*;

	index_fmt_t         index_format_q;
	value_width_t       value_width_q;
	logic [ThreshW-1:0] threshold_q;
	logic [WordW-1:0]   prev_row_q;

	logic               valid_s1;
	logic               first_s1;
	logic [WordW-1:0]   col_s1;
	logic [WordW-1:0]   code_s1;
	logic [WordW-1:0]   ovf_s1;
	logic [WordW-1:0]   vcode_s1;

	logic               valid_s2;
	logic [WordW-1:0]   row_s2;
	value_res_t         res_s2;

	logic               adv_s2;
	logic               adv_s1;
	logic [WordW-1:0]   delta16;
	logic [WordW-1:0]   row;
	value_res_t         res;

	// handshake: stage 2 frees when empty or taken, stage 1 when it can move on
	assign adv_s2       = !valid_s2 || result.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign entry.ready  = adv_s1;
	assign result.valid = valid_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_format_q <= IDX_DELTA32;
			value_width_q  <= VW_16;
			threshold_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INDEX_FORMAT: index_format_q <= index_fmt_t'(cfg_data[1:0]);
				CFG_VALUE_WIDTH:  value_width_q  <= value_width_t'(cfg_data[1:0]);
				CFG_THRESHOLD:    threshold_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and row accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			prev_row_q <= '0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= entry.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					prev_row_q <= row;
				end
			end
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && entry.valid) begin
			first_s1 <= entry.first_of_column;
			col_s1   <= entry.column_index;
			code_s1  <= entry.index_code;
			ovf_s1   <= entry.overflow_delta;
			vcode_s1 <= entry.value_code;
		end
	end

	// 16-bit delta: sign-extend, or take the overflow delta on escape
	assign delta16 = (code_s1[15:0] == ESCAPE_CODE) ? ovf_s1
		: {{16{code_s1[15]}}, code_s1[15:0]};

	// decode the row from the code word, column or previous row
	always_comb begin
		unique case (index_format_q)
			IDX_RAW:     row = code_s1;
			IDX_DELTA16: row = first_s1 ? (col_s1 - delta16) : (prev_row_q + delta16);
			default:     row = first_s1 ? (col_s1 + code_s1) : (prev_row_q + code_s1);
		endcase
	end

	scedec_value u_value (
		.value_code  (vcode_s1),
		.value_width (value_width_q),
		.threshold   (threshold_q),
		.res         (res)
	);

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			row_s2 <= row;
			res_s2 <= res;
		end
	end

	assign result.row_index   = row_s2;
	assign result.value_q2_30 = res_s2.value_q2_30;
	assign result.value_is_na = res_s2.value_is_na;
	assign result.is_neighbor = res_s2.is_neighbor;

endmodule

### sv/scedec_value.sv
// Dequantizer: signed value code to Q2.30 with NA detect and threshold flag
module scedec_value (
	input  logic [scedec_pkg::WordW-1:0]   value_code,
	input  scedec_pkg::value_width_t       value_width,
	input  logic [scedec_pkg::ThreshW-1:0] threshold,
	output scedec_pkg::value_res_t         res
);
	import scedec_pkg::*;

	logic [WordW-1:0]   neg_code;
	logic               neg;
	logic               na;
	logic [6:0]         mag8;
	logic [14:0]        mag16;
	logic [30:0]        mag32;
	logic [30:0]        q8;
	logic [30:0]        q16;
	logic [31:0]        sum32;
	logic [2:0]         round8;
	logic [ThreshW-1:0] q;
	logic [WordW-1:0]   q_ext;

	// one negator serves all widths: low bits of -code are -low bits
	assign neg_code = 32'd0 - value_code;

	assign mag8  = value_code[7]  ? neg_code[6:0]  : value_code[6:0];
	assign mag16 = value_code[15] ? neg_code[14:0] : value_code[14:0];
	assign mag32 = value_code[31] ? neg_code[30:0] : value_code[30:0];

	// 8-bit: m*2^30/127 = m*RECIP + 4m/127; round the fraction by thresholds
	assign round8 = 3'(mag8 >= 7'd16) + 3'(mag8 >= 7'd48) + 3'(mag8 >= 7'd80)
		+ 3'(mag8 >= 7'd112);
	assign q8 = 31'(mag8 * RECIP_Q8) + 31'(round8);

	// 16-bit: m*2^30/32767 = m*2^15 + m + m/32767; round up when 2m >= 32767
	assign q16 = {1'b0, mag16, 15'd0} + 31'(mag16) + 31'(mag16[14]);

	// 32-bit: m*2^30/(2^31-1) rounds to (m+1)/2
	assign sum32 = {1'b0, mag32} + 32'd1;

	// select by width
	always_comb begin
		unique case (value_width)
			VW_8: begin
				neg = value_code[7];
				na  = (value_code[7:0] == 8'h80);
				q   = q8;
			end
			VW_16: begin
				neg = value_code[15];
				na  = (value_code[15:0] == 16'h8000);
				q   = q16;
			end
			default: begin
				neg = value_code[31];
				na  = (value_code == 32'h8000_0000);
				q   = sum32[31:1];
			end
		endcase
	end

	assign q_ext = {1'b0, q};

	// apply sign, zero on NA, compare magnitude with threshold
	always_comb begin
		res.value_is_na = na;
		if (na) begin
			res.value_q2_30 = '0;
			res.is_neighbor = 1'b0;
		end else begin
			res.value_q2_30 = neg ? signed'(32'd0 - q_ext) : signed'(q_ext);
			res.is_neighbor = (q >= threshold);
		end
	end

endmodule

### sv/scedec_checker.sv
// Port-level checks for the sparse column entry decoder, bound to the top level
`include "sparse_column_entry_decoder_top_defines.svh"

module scedec_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [scedec_pkg::WordW-1:0]   row_index,
	input logic signed [scedec_pkg::WordW-1:0] value_q2_30,
	input logic                           value_is_na,
	input logic                           is_neighbor
);
	import scedec_pkg::*;

	// a stalled result keeps its row and value
	`SCEDEC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(value_q2_30), "stalled result changed")

	// NA results carry zero and no neighbor flag
	`SCEDEC_ASSERT_SAME(a_na_zero, clk, arst_n, out_valid && value_is_na, value_q2_30 == 32'sd0 && !is_neighbor, "NA result not cleared")

	// dequantized magnitude stays within one in Q2.30
	`SCEDEC_ASSERT_SAME(a_range, clk, arst_n, out_valid, value_q2_30 <= 32'sh4000_0000 && value_q2_30 >= -32'sh4000_0000, "value out of Q2.30 range")

	// an entry taken while no result is shown leads to a result through the input and result registers
	`SCEDEC_ASSERT_NEXT(a_flow, clk, arst_n, in_valid && in_ready && !out_valid, ##1 out_valid, "accepted entry produced no result")

endmodule

bind sparse_column_entry_decoder_top scedec_checker u_scedec_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (entry.valid),
	.in_ready    (entry.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.row_index   (result.row_index),
	.value_q2_30 (result.value_q2_30),
	.value_is_na (result.value_is_na),
	.is_neighbor (result.is_neighbor)
);
